// ===== design/dusr_pkg.sv =====
// shared types and constants of the dual ultrasonic range sequencer
package dusr_pkg;

    // field and register widths
    localparam int DIST_W    = 11;
    localparam int TICK_W    = 14;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int BAR_W     = 4;

    // saturation limit of the tick counter
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // cm = floor(count * 0.272), done as (count * CM_MUL) >> CM_SHIFT
    // exact for every count up to CM_CLAMP, which already maps to 2047 cm
    localparam int                 MUL_W    = 19;
    localparam logic [MUL_W-1:0]   CM_MUL   = 19'd285213;
    localparam int                 CM_SHIFT = 20;
    localparam logic [CFG_W-1:0]   CM_CLAMP = 13'd7529;

    // register reset values
    localparam logic [CFG_W-1:0]  WINDOW_RST      = 13'd4062;
    localparam logic [CFG_W-1:0]  MIN_ECHO_RST    = 13'd8;
    localparam logic [DIST_W-1:0] LEVEL_FOUR_RST  = 11'd10;
    localparam logic [DIST_W-1:0] LEVEL_THREE_RST = 11'd50;
    localparam logic [DIST_W-1:0] LEVEL_TWO_RST   = 11'd100;
    localparam logic [DIST_W-1:0] LEVEL_ONE_RST   = 11'd200;

    // thermometer patterns
    localparam logic [BAR_W-1:0] BAR_FOUR  = 4'hF;
    localparam logic [BAR_W-1:0] BAR_THREE = 4'h7;
    localparam logic [BAR_W-1:0] BAR_TWO   = 4'h3;
    localparam logic [BAR_W-1:0] BAR_ONE   = 4'h1;
    localparam logic [BAR_W-1:0] BAR_NONE  = 4'h0;

    // measurement sequencer phases
    typedef enum logic [2:0] {
        PH_PULSE   = 3'b001,
        PH_DETECT  = 3'b010,
        PH_CONVERT = 3'b100
    } phase_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW      = 3'd0,
        REG_MIN_ECHO    = 3'd1,
        REG_LEVEL_FOUR  = 3'd2,
        REG_LEVEL_THREE = 3'd3,
        REG_LEVEL_TWO   = 3'd4,
        REG_LEVEL_ONE   = 3'd5
    } cfg_idx_t;

    // led bar thresholds
    typedef struct packed {
        logic [DIST_W-1:0] four;
        logic [DIST_W-1:0] three;
        logic [DIST_W-1:0] two;
        logic [DIST_W-1:0] one;
    } levels_t;

    // one result word
    typedef struct packed {
        logic              measure_done;
        logic [BAR_W-1:0]  led_bar;
        logic [DIST_W-1:0] nearest_cm;
        logic [DIST_W-1:0] back_cm;
        logic [DIST_W-1:0] rear_cm;
        logic              trigger;
    } result_t;

endpackage

// ===== design/dusr_dist_conv.sv =====
// echo count to centimetre conversion with minimum-count hold
module dusr_dist_conv #(
    parameter int COUNT_WIDTH = 13
) (
    input  logic [COUNT_WIDTH-1:0]      count,
    input  logic [dusr_pkg::CFG_W-1:0]  min_echo,
    input  logic [dusr_pkg::DIST_W-1:0] old_cm,
    output logic [dusr_pkg::DIST_W-1:0] new_cm
);
    import dusr_pkg::*;

    localparam int CMP_W  = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam int PROD_W = CFG_W + MUL_W;

    logic [CMP_W-1:0]  count_ext;
    logic [CMP_W-1:0]  min_ext;
    logic [CMP_W-1:0]  clamp_ext;
    logic [CFG_W-1:0]  count_clamped;
    logic [PROD_W-1:0] product;

    // clamp where the distance saturates, then scale by 0.272
    always_comb begin
        count_ext     = CMP_W'(count);
        min_ext       = CMP_W'(min_echo);
        clamp_ext     = CMP_W'(CM_CLAMP);
        count_clamped = (count_ext >= clamp_ext) ? CM_CLAMP : CFG_W'(count_ext);
        product       = PROD_W'(count_clamped) * PROD_W'(CM_MUL);
        new_cm        = (count_ext >= min_ext) ? product[CM_SHIFT +: DIST_W] : old_cm;
    end

endmodule

// ===== design/dusr_led_bar.sv =====
// thermometer led bar from the nearest distance
module dusr_led_bar (
    input  logic [dusr_pkg::DIST_W-1:0] nearest,
    input  dusr_pkg::levels_t           levels,
    output logic [dusr_pkg::BAR_W-1:0]  bar
);
    import dusr_pkg::*;

    // level four is tested first, then three, two and one; the first match wins
    always_comb begin
        if (nearest <= levels.four) begin
            bar = BAR_FOUR;
        end else if (nearest <= levels.three) begin
            bar = BAR_THREE;
        end else if (nearest <= levels.two) begin
            bar = BAR_TWO;
        end else if (nearest <= levels.one) begin
            bar = BAR_ONE;
        end else begin
            bar = BAR_NONE;
        end
    end

endmodule

// ===== design/dual_ultrasonic_range_sequencer_unit.sv =====
// top level of the dual ultrasonic range sequencer
//
// Each input word is one 16 us tick carrying the rear and back echo levels;
// each accepted word produces exactly one result word. A measurement raises
// the shared trigger for one tick, counts echo-high ticks per sensor while
// the tick count is within window_ticks, then, on the tick after the one
// that passes window_ticks, converts the counts to cm (measure_done /
// m_tlast high) and restarts, so one measurement spans window_ticks + 2
// words (three words when window_ticks is zero). Throughput is one word per
// clock unless m_tready stalls the output; a word passes an input register
// and then the result register that drives m_tvalid. Configuration writes
// take effect at once and are meant for idle periods only.
module dual_ultrasonic_range_sequencer_unit #(
    parameter int COUNT_WIDTH = 13
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input words
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,    // echo_rear, echo_back, zero pad
    // result words
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [39:0]                    m_tdata,    // trigger, rear_cm, back_cm,
                                                       // nearest_cm, led_bar, zero pad
    output logic                           m_tlast,    // measure_done
    // configuration writes
    input  logic                           cfg_wr_en,
    input  logic [dusr_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [dusr_pkg::CFG_W-1:0]     cfg_wr_data
);
    import dusr_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] ECHO_MAX = '1;

    // configuration registers
    logic [CFG_W-1:0] window_reg;
    logic [CFG_W-1:0] min_echo_reg;
    levels_t          levels_reg;

    // input stage
    logic in_valid_reg, in_valid_next;
    logic echo_rear_reg;
    logic echo_back_reg;

    // measurement state
    phase_t                 phase_reg, phase_next;
    logic [TICK_W-1:0]      tick_count_reg, tick_count_next;
    logic [TICK_W-1:0]      tick_inc;
    logic [COUNT_WIDTH-1:0] rear_count_reg, rear_count_next;
    logic [COUNT_WIDTH-1:0] back_count_reg, back_count_next;
    logic [DIST_W-1:0]      rear_dist_reg, rear_dist_next;
    logic [DIST_W-1:0]      back_dist_reg, back_dist_next;
    logic [DIST_W-1:0]      nearest_reg, nearest_next;
    logic                   trigger_reg, trigger_next;
    logic                   done_next;

    // result stage
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;

    logic              advance;
    logic              fire;
    logic [DIST_W-1:0] rear_conv;
    logic [DIST_W-1:0] back_conv;
    logic [BAR_W-1:0]  bar_next;

    // handshake: result register frees, input register follows
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // configuration write decoder
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg       <= WINDOW_RST;
            min_echo_reg     <= MIN_ECHO_RST;
            levels_reg.four  <= LEVEL_FOUR_RST;
            levels_reg.three <= LEVEL_THREE_RST;
            levels_reg.two   <= LEVEL_TWO_RST;
            levels_reg.one   <= LEVEL_ONE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_WINDOW:      window_reg       <= cfg_wr_data;
                REG_MIN_ECHO:    min_echo_reg     <= cfg_wr_data;
                REG_LEVEL_FOUR:  levels_reg.four  <= cfg_wr_data[DIST_W-1:0];
                REG_LEVEL_THREE: levels_reg.three <= cfg_wr_data[DIST_W-1:0];
                REG_LEVEL_TWO:   levels_reg.two   <= cfg_wr_data[DIST_W-1:0];
                REG_LEVEL_ONE:   levels_reg.one   <= cfg_wr_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_comb begin
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            echo_rear_reg <= s_tdata[0];
            echo_back_reg <= s_tdata[1];
        end
    end

    // distance conversion of both sensors
    dusr_dist_conv #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_conv_rear (
        .count    (rear_count_reg),
        .min_echo (min_echo_reg),
        .old_cm   (rear_dist_reg),
        .new_cm   (rear_conv)
    );

    dusr_dist_conv #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_conv_back (
        .count    (back_count_reg),
        .min_echo (min_echo_reg),
        .old_cm   (back_dist_reg),
        .new_cm   (back_conv)
    );

    // saturating tick increment
    assign tick_inc = (tick_count_reg == TICK_MAX) ? tick_count_reg
                                                   : tick_count_reg + TICK_W'(1);

    // measurement sequencer
    always_comb begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        rear_count_next = rear_count_reg;
        back_count_next = back_count_reg;
        rear_dist_next  = rear_dist_reg;
        back_dist_next  = back_dist_reg;
        nearest_next    = nearest_reg;
        trigger_next    = trigger_reg;
        done_next       = 1'b0;
        if (fire) begin
            tick_count_next = tick_inc;
            unique case (phase_reg)
                PH_DETECT: begin
                    trigger_next = 1'b0;
                    if (tick_inc <= TICK_W'(window_reg)) begin
                        if (echo_rear_reg && (rear_count_reg != ECHO_MAX)) begin
                            rear_count_next = rear_count_reg + COUNT_WIDTH'(1);
                        end
                        if (echo_back_reg && (back_count_reg != ECHO_MAX)) begin
                            back_count_next = back_count_reg + COUNT_WIDTH'(1);
                        end
                    end else begin
                        phase_next = PH_CONVERT;
                    end
                end
                PH_CONVERT: begin
                    rear_dist_next  = rear_conv;
                    back_dist_next  = back_conv;
                    nearest_next    = (rear_conv <= back_conv) ? rear_conv : back_conv;
                    rear_count_next = '0;
                    back_count_next = '0;
                    tick_count_next = '0;
                    phase_next      = PH_PULSE;
                    done_next       = 1'b1;
                end
                default: begin
                    // pulse phase, also taken by any stray code
                    if (tick_inc <= TICK_W'(1)) begin
                        trigger_next    = 1'b1;
                        rear_count_next = '0;
                        back_count_next = '0;
                        phase_next      = PH_DETECT;
                    end else begin
                        phase_next = PH_PULSE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_PULSE;
            tick_count_reg <= '0;
            rear_count_reg <= '0;
            back_count_reg <= '0;
            rear_dist_reg  <= '0;
            back_dist_reg  <= '0;
            nearest_reg    <= '0;
            trigger_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            rear_count_reg <= rear_count_next;
            back_count_reg <= back_count_next;
            rear_dist_reg  <= rear_dist_next;
            back_dist_reg  <= back_dist_next;
            nearest_reg    <= nearest_next;
            trigger_reg    <= trigger_next;
        end
    end

    // led bar from the updated nearest distance
    dusr_led_bar u_led_bar (
        .nearest (nearest_next),
        .levels  (levels_reg),
        .bar     (bar_next)
    );

    // result register
    always_comb begin
        out_data_next.trigger      = trigger_next;
        out_data_next.rear_cm      = rear_dist_next;
        out_data_next.back_cm      = back_dist_next;
        out_data_next.nearest_cm   = nearest_next;
        out_data_next.led_bar      = bar_next;
        out_data_next.measure_done = done_next;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_data_reg.measure_done;
    assign m_tdata  = {2'b00,
                       out_data_reg.led_bar,
                       out_data_reg.nearest_cm,
                       out_data_reg.back_cm,
                       out_data_reg.rear_cm,
                       out_data_reg.trigger};

`ifndef SYNTHESIS
    // the finishing word never carries a trigger pulse
    a_done_no_trigger: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.measure_done) |-> !out_data_reg.trigger)
        else $error("trigger high on a measurement-done word");

    // stored nearest distance is the smaller of the two stored distances
    a_nearest_is_min: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((out_data_reg.nearest_cm <= out_data_reg.rear_cm) &&
                           (out_data_reg.nearest_cm <= out_data_reg.back_cm)))
        else $error("nearest distance exceeds a sensor distance");

    // a finished measurement restarts the tick count and echo counts
    a_done_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && done_next) |=> ((tick_count_reg == '0) && (rear_count_reg == '0) &&
                                 (back_count_reg == '0) && (phase_reg == PH_PULSE)))
        else $error("measurement state not restarted after conversion");
`endif

endmodule

// ===== sim/dual_ultrasonic_range_sequencer_unit_tb.sv =====
// testbench of the dual ultrasonic range sequencer: tick stream checked against a predictor
`timescale 1ns / 100ps

module dual_ultrasonic_range_sequencer_unit_tb;
    import dusr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 520;
    localparam logic [CFG_W-1:0]     ECHO_SAT        = '1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_SIX   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_SEVEN = 3'd7;

    typedef enum int {STIM_NOISE, STIM_PULSE, STIM_LONG} stim_style_t;
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // one register setting plus the traffic that runs under it
    typedef struct {
        logic [CFG_W-1:0]  window;
        logic [CFG_W-1:0]  min_echo;
        logic [DIST_W-1:0] lvl_four;
        logic [DIST_W-1:0] lvl_three;
        logic [DIST_W-1:0] lvl_two;
        logic [DIST_W-1:0] lvl_one;
        int                items;
        idle_mode_t        idle;
        stim_style_t       style;
    } setting_t;

    // directed row: echo levels and, where obvious, the typed-in result
    typedef struct packed {
        logic    er;
        logic    eb;
        bit      typed;
        result_t res;
    } tick_row_t;

    localparam result_t NO_RES   = '0;
    localparam result_t TRIG_RES = '{measure_done: 1'b0, led_bar: BAR_FOUR, nearest_cm: 11'd0,
                                     back_cm: 11'd0, rear_cm: 11'd0, trigger: 1'b1};
    localparam result_t QUIET_RES = '{measure_done: 1'b0, led_bar: BAR_FOUR, nearest_cm: 11'd0,
                                      back_cm: 11'd0, rear_cm: 11'd0, trigger: 1'b0};

    // after reset with default registers: trigger tick, then plain sampling
    localparam tick_row_t DIRECTED_ROWS [24] = '{
        '{1'b0, 1'b0, 1'b1, TRIG_RES},
        '{1'b1, 1'b1, 1'b1, QUIET_RES},
        '{1'b1, 1'b0, 1'b1, QUIET_RES},
        '{1'b0, 1'b1, 1'b0, NO_RES},
        '{1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b1, 1'b1, 1'b0, NO_RES},
        '{1'b1, 1'b1, 1'b0, NO_RES},
        '{1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 1'b1, 1'b0, NO_RES},
        '{1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 1'b1, 1'b0, NO_RES},
        '{1'b1, 1'b1, 1'b0, NO_RES},
        '{1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b1, 1'b1, 1'b0, NO_RES},
        '{1'b1, 1'b1, 1'b0, NO_RES},
        '{1'b1, 1'b1, 1'b0, NO_RES},
        '{1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 1'b1, 1'b0, NO_RES},
        '{1'b0, 1'b1, 1'b0, NO_RES},
        '{1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b1, 1'b1, 1'b0, NO_RES},
        '{1'b0, 1'b0, 1'b0, NO_RES}
    };

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata     = '0;   // echo_rear, echo_back, zero pad
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [39:0]          m_tdata;            // trigger, rear_cm, back_cm, nearest_cm,
                                              // led_bar, zero pad
    logic                 m_tlast;            // measure_done
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr    = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;

    dual_ultrasonic_range_sequencer_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // mirrored registers and sequencer state
    logic [CFG_W-1:0]  win_ticks;
    logic [CFG_W-1:0]  min_ticks;
    levels_t           levels;
    phase_t            ph;
    logic [TICK_W-1:0] ticks;
    logic [CFG_W-1:0]  rear_cnt;
    logic [CFG_W-1:0]  back_cnt;
    logic [DIST_W-1:0] rear_d;
    logic [DIST_W-1:0] back_d;
    logic [DIST_W-1:0] near_d;
    logic              trig;

    result_t     due_readings[$];
    int          fault_count  = 0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;

    // echo pulse shaping
    stim_style_t style     = STIM_NOISE;
    int          span      = 1;
    int          rear_wait = 0;
    int          rear_len  = 0;
    int          back_wait = 0;
    int          back_len  = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic void range_reset();
        win_ticks    = WINDOW_RST;
        min_ticks    = MIN_ECHO_RST;
        levels.four  = LEVEL_FOUR_RST;
        levels.three = LEVEL_THREE_RST;
        levels.two   = LEVEL_TWO_RST;
        levels.one   = LEVEL_ONE_RST;
        ph           = PH_PULSE;
        ticks        = '0;
        rear_cnt     = '0;
        back_cnt     = '0;
        rear_d       = '0;
        back_d       = '0;
        near_d       = '0;
        trig         = 1'b0;
    endfunction

    // floor(count * 0.272), clamped to the distance range
    function automatic logic [DIST_W-1:0] echo_to_cm(logic [CFG_W-1:0] cnt);
        int unsigned cm;
        cm = (32'(cnt) * 32'd272) / 32'd1000;
        return (cm > 32'd2047) ? '1 : cm[DIST_W-1:0];
    endfunction

    function automatic logic [BAR_W-1:0] bar_for(logic [DIST_W-1:0] d);
        if (d <= levels.four) return BAR_FOUR;
        if (d <= levels.three) return BAR_THREE;
        if (d <= levels.two) return BAR_TWO;
        if (d <= levels.one) return BAR_ONE;
        return BAR_NONE;
    endfunction

    // advance the sequencer by one tick and return its result word
    function automatic result_t range_step(logic er, logic eb);
        logic    done;
        result_t r;
        done = 1'b0;
        if (ticks != TICK_MAX) ticks = ticks + 1'b1;
        case (ph)
            PH_DETECT: begin
                trig = 1'b0;
                if (ticks <= {1'b0, win_ticks}) begin
                    if (er && rear_cnt != ECHO_SAT) rear_cnt = rear_cnt + 1'b1;
                    if (eb && back_cnt != ECHO_SAT) back_cnt = back_cnt + 1'b1;
                end else begin
                    ph = PH_CONVERT;
                end
            end
            PH_CONVERT: begin
                if (rear_cnt >= min_ticks) rear_d = echo_to_cm(rear_cnt);
                if (back_cnt >= min_ticks) back_d = echo_to_cm(back_cnt);
                near_d   = (rear_d <= back_d) ? rear_d : back_d;
                rear_cnt = '0;
                back_cnt = '0;
                ticks    = '0;
                ph       = PH_PULSE;
                done     = 1'b1;
            end
            default: begin
                // unused codes behave as the pulse phase
                if (ticks <= TICK_W'(1)) begin
                    trig     = 1'b1;
                    rear_cnt = '0;
                    back_cnt = '0;
                    ph       = PH_DETECT;
                end else begin
                    ph = PH_PULSE;
                end
            end
        endcase
        r.trigger      = trig;
        r.rear_cm      = rear_d;
        r.back_cm      = back_d;
        r.nearest_cm   = near_d;
        r.led_bar      = bar_for(near_d);
        r.measure_done = done;
        return r;
    endfunction

    // echo levels for the next word, per stimulus style
    function automatic logic [1:0] pick_echoes(int idx);
        logic er;
        logic eb;
        case (style)
            STIM_NOISE: begin
                er = 1'($urandom_range(0, 1));
                eb = 1'($urandom_range(0, 1));
            end
            STIM_LONG: begin
                er = 1'b1;
                eb = (idx < 120);
            end
            default: begin
                er = (rear_wait == 0) && (rear_len > 0);
                eb = (back_wait == 0) && (back_len > 0);
                if (rear_wait > 0) rear_wait--;
                else if (rear_len > 0) rear_len--;
                if (back_wait > 0) back_wait--;
                else if (back_len > 0) back_len--;
                // occasional glitches on the echo lines
                if ($urandom_range(0, 19) == 0) er = ~er;
                if ($urandom_range(0, 19) == 0) eb = ~eb;
            end
        endcase
        return {eb, er};
    endfunction

    // offer one word, wait for acceptance, record what must come back
    task automatic send_tick(input logic er, input logic eb, input bit typed,
                             input result_t typed_res);
        result_t r;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, eb, er};
        do @(posedge aclk); while (!s_tready);
        r = range_step(er, eb);
        due_readings.push_back(typed ? typed_res : r);
        // a new trigger starts fresh echo pulses
        if (r.trigger) begin
            rear_wait = $urandom_range(0, span / 3);
            rear_len  = $urandom_range(0, span);
            back_wait = $urandom_range(0, span / 3);
            back_len  = $urandom_range(0, span);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (due_readings.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // one register write; the caller lowers the enable after a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        case (idx)
            REG_WINDOW:      win_ticks    = val;
            REG_MIN_ECHO:    min_ticks    = val;
            REG_LEVEL_FOUR:  levels.four  = val[DIST_W-1:0];
            REG_LEVEL_THREE: levels.three = val[DIST_W-1:0];
            REG_LEVEL_TWO:   levels.two   = val[DIST_W-1:0];
            REG_LEVEL_ONE:   levels.one   = val[DIST_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input setting_t s);
        drain_results();
        // junk in the upper bits of level writes must be dropped
        write_reg(REG_WINDOW, s.window);
        write_reg(REG_MIN_ECHO, s.min_echo);
        write_reg(REG_LEVEL_FOUR, {2'($urandom_range(0, 3)), s.lvl_four});
        write_reg(REG_LEVEL_THREE, {2'($urandom_range(0, 3)), s.lvl_three});
        write_reg(REG_LEVEL_TWO, {2'($urandom_range(0, 3)), s.lvl_two});
        write_reg(REG_LEVEL_ONE, {2'($urandom_range(0, 3)), s.lvl_one});
        write_reg(REG_SPARE_SIX, CFG_W'($urandom));
        write_reg(REG_SPARE_SEVEN, CFG_W'($urandom));
        cfg_wr_en <= 1'b0;

        case (s.idle)
            IDLE_SENDER:   begin tx_idle_pct = 64; rx_stall_pct = 0;  end
            IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
            IDLE_BOTH:     begin tx_idle_pct = 17; rx_stall_pct = 17; end
            default:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        endcase
        style     = s.style;
        span      = (s.window < 2) ? 2 : int'(s.window);
        rear_wait = 0;
        rear_len  = 0;
        back_wait = 0;
        back_len  = 0;

        for (int i = 0; i < s.items; i++) begin
            logic [1:0] e;
            e = pick_echoes(i);
            send_tick(e[0], e[1], 1'b0, NO_RES);
        end
    endtask

    function automatic setting_t random_setting(int k);
        setting_t    s;
        int unsigned top_cm;
        case ($urandom_range(0, 7))
            0:       s.window = CFG_W'($urandom_range(0, 1));
            1:       s.window = CFG_W'($urandom_range(61, 400));
            default: s.window = CFG_W'($urandom_range(2, 60));
        endcase
        s.min_echo = CFG_W'($urandom_range(0, 32'(s.window) / 2 + 1));
        top_cm     = (32'(s.window) * 32'd272) / 32'd1000 + 2;
        if ($urandom_range(0, 1)) begin
            // ordered thresholds as in normal use
            s.lvl_four  = DIST_W'($urandom_range(0, top_cm / 3));
            s.lvl_three = s.lvl_four + DIST_W'($urandom_range(0, top_cm / 3 + 1));
            s.lvl_two   = s.lvl_three + DIST_W'($urandom_range(0, top_cm / 3 + 1));
            s.lvl_one   = s.lvl_two + DIST_W'($urandom_range(0, top_cm / 3 + 1));
        end else begin
            s.lvl_four  = DIST_W'($urandom_range(0, top_cm));
            s.lvl_three = DIST_W'($urandom_range(0, top_cm));
            s.lvl_two   = DIST_W'($urandom_range(0, top_cm));
            s.lvl_one   = DIST_W'($urandom_range(0, top_cm));
        end
        s.items = $urandom_range(60, 160);
        s.idle  = idle_mode_t'(k % 4);
        s.style = ($urandom_range(0, 3) == 0) ? STIM_NOISE : STIM_PULSE;
        return s;
    endfunction

    // receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    function automatic void check_field(string name, logic [DIST_W-1:0] want,
                                        logic [DIST_W-1:0] got);
        if (got !== want) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fault_count++;
        end
    endfunction

    // result word check against the oldest expectation
    always @(posedge aclk) begin
        result_t seen;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = {m_tlast, m_tdata[37:0]};
            if (due_readings.size() == 0) begin
                $error("result word with nothing expected: tdata %h tlast %b", m_tdata, m_tlast);
                fault_count++;
            end else begin
                want = due_readings.pop_front();
                check_field("trigger", DIST_W'(want.trigger), DIST_W'(seen.trigger));
                check_field("rear_cm", want.rear_cm, seen.rear_cm);
                check_field("back_cm", want.back_cm, seen.back_cm);
                check_field("nearest_cm", want.nearest_cm, seen.nearest_cm);
                check_field("led_bar", DIST_W'(want.led_bar), DIST_W'(seen.led_bar));
                check_field("measure_done", DIST_W'(want.measure_done),
                            DIST_W'(seen.measure_done));
                check_field("tdata pad", '0, DIST_W'(m_tdata[39:38]));
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    int stuck_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        setting_t preset[6];
        setting_t s;
        int       random_sent;
        int       k;

        range_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows under reset defaults
        for (int i = 0; i < 24; i++) begin
            send_tick(DIRECTED_ROWS[i].er, DIRECTED_ROWS[i].eb, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].res);
        end

        // smallest windows, minimum of zero or one and extreme thresholds
        preset[0] = '{window: 13'd2, min_echo: 13'd0, lvl_four: 11'd0, lvl_three: 11'd0,
                      lvl_two: 11'd0, lvl_one: 11'd0, items: 40, idle: IDLE_NONE,
                      style: STIM_NOISE};
        preset[1] = '{window: 13'd0, min_echo: 13'd1, lvl_four: 11'd2047, lvl_three: 11'd2047,
                      lvl_two: 11'd2047, lvl_one: 11'd2047, items: 30, idle: IDLE_SENDER,
                      style: STIM_NOISE};
        preset[2] = '{window: 13'd1, min_echo: 13'd0, lvl_four: 11'd1, lvl_three: 11'd1,
                      lvl_two: 11'd1, lvl_one: 11'd1, items: 30, idle: IDLE_RECEIVER,
                      style: STIM_PULSE};
        // long window with a steady rear echo and a shorter back echo
        preset[3] = '{window: 13'd300, min_echo: 13'd0, lvl_four: 11'd10, lvl_three: 11'd40,
                      lvl_two: 11'd60, lvl_one: 11'd90, items: 320, idle: IDLE_BOTH,
                      style: STIM_LONG};
        // minimum too high: stored distances never change
        preset[4] = '{window: 13'd30, min_echo: 13'd8191, lvl_four: 11'd800, lvl_three: 11'd810,
                      lvl_two: 11'd815, lvl_one: 11'd816, items: 70, idle: IDLE_NONE,
                      style: STIM_PULSE};
        preset[5] = '{window: 13'd13, min_echo: 13'd8, lvl_four: 11'd10, lvl_three: 11'd50,
                      lvl_two: 11'd100, lvl_one: 11'd200, items: 50, idle: IDLE_SENDER,
                      style: STIM_PULSE};
        for (int i = 0; i < 6; i++) run_phase(preset[i]);

        // random settings and traffic
        random_sent = 0;
        k = 0;
        while (random_sent < RANDOM_ITEMS) begin
            s = random_setting(k);
            run_phase(s);
            random_sent += s.items;
            k++;
        end

        drain_results();
        repeat (6) @(posedge aclk);
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
